### hdl/hnabe_pkg.sv
// ----------------------------------------------------------------------------
// hnabe_pkg
// Shared constants and types for the HDLC NRZI AFSK bit encoder.
// ----------------------------------------------------------------------------
package hnabe_pkg;

  // run of ones that forces an inserted zero
  localparam int ONES_LIMIT  = 5;
  // number of waveform phases, stepped down after every space bit
  localparam int PHASE_STEPS = 6;

  // field widths
  localparam int BYTE_BITS = 8;
  localparam int PHASE_W   = 3;
  localparam int ONES_W    = 3;
  localparam int REM_W     = $clog2(BYTE_BITS + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // register indexes
  localparam logic REG_NRZI_ENABLE = 1'b0;

  // one bit handed to the line coder
  typedef struct packed {
    logic fire;
    logic bit_val;
  } bit_req_t;

endpackage

### hdl/hnabe_if.sv
// ----------------------------------------------------------------------------
// hnabe_if
// Valid/ready channels for input bytes and emitted line bits.
// ----------------------------------------------------------------------------

// byte channel
interface hnabe_byte_if;
  logic                           valid;
  logic                           ready;
  logic [hnabe_pkg::BYTE_BITS-1:0] data_byte;
  logic                           stuff_enable;
  logic                           clear_ones;

  modport source (output valid, output data_byte, output stuff_enable, output clear_ones,
                  input ready);
  modport sink (input valid, input data_byte, input stuff_enable, input clear_ones,
                output ready);
endinterface

// line bit channel
interface hnabe_bit_if;
  logic                          valid;
  logic                          ready;
  logic                          line_level;
  logic [hnabe_pkg::PHASE_W-1:0] phase_index;
  logic                          is_stuffed;
  logic                          last_bit;

  modport source (output valid, output line_level, output phase_index, output is_stuffed,
                  output last_bit, input ready);
  modport sink (input valid, input line_level, input phase_index, input is_stuffed,
                input last_bit, output ready);
endinterface

### hdl/hnabe_line_coder.sv
// ----------------------------------------------------------------------------
// hnabe_line_coder
// NRZI or plain level coding with the waveform phase that follows it.
// ----------------------------------------------------------------------------
module hnabe_line_coder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          nrzi_en_i,
  input  hnabe_pkg::bit_req_t           req_i,
  output logic                          level_o,
  output logic [hnabe_pkg::PHASE_W-1:0] phase_o
);

  logic                          level_q, level_d;
  logic [hnabe_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                          level_new;

  // level for the bit now presented: toggle on zero, or follow the bit
  always_comb begin
    if (nrzi_en_i) begin
      level_new = level_q ^ ~req_i.bit_val;
    end else begin
      level_new = req_i.bit_val;
    end
  end

  assign level_o = level_new;
  assign phase_o = phase_q;

  // phase steps down cyclically after a space bit
  always_comb begin
    level_d = level_q;
    phase_d = phase_q;
    if (req_i.fire) begin
      level_d = level_new;
      if (!level_new) begin
        if (phase_q == '0) begin
          phase_d = hnabe_pkg::PHASE_W'(hnabe_pkg::PHASE_STEPS - 1);
        end else begin
          phase_d = phase_q - hnabe_pkg::PHASE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      phase_q <= '0;
    end else begin
      level_q <= level_d;
      phase_q <= phase_d;
    end
  end

endmodule

### hdl/hdlc_nrzi_afsk_bit_encoder.sv
// ----------------------------------------------------------------------------
// hdlc_nrzi_afsk_bit_encoder
// HDLC bit stuffing and NRZI or plain line coding, one line bit per cycle unless stalled.
// ----------------------------------------------------------------------------
// A byte is taken on the input channel and shifted out LSB first through an
// 8-bit shift register, one line bit per cycle while the output is not stalled.
// With stuffing on, a zero is inserted after every run of five ones, so a byte
// yields 8 to 10 output items; the next byte is taken in the cycle that its
// predecessor's last bit goes into the output register. Each item carries the
// coded level, the waveform phase for its sample block, the inserted-zero flag
// and the last-bit flag. Output stalls hold the shift register. Register 0
// (byte address 0, bit 0) selects NRZI coding and resets to 1; the user must
// write it only while the encoder is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module hdlc_nrzi_afsk_bit_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  hnabe_byte_if.sink                           in_chan,
  hnabe_bit_if.source                          out_chan,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hnabe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hnabe_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hnabe_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  logic                            nrzi_q;
  logic [hnabe_pkg::BYTE_BITS-1:0] data_q, data_d;
  logic                            stuff_q, stuff_d;
  logic [hnabe_pkg::REM_W-1:0]     rem_q, rem_d;
  logic                            pend_q, pend_d;
  logic [hnabe_pkg::ONES_W-1:0]    ones_q, ones_d;
  logic [hnabe_pkg::ONES_W:0]      ones_sum;

  logic                            out_valid_q, out_valid_d;
  logic                            level_q;
  logic [hnabe_pkg::PHASE_W-1:0]   phase_q;
  logic                            stuffed_q;
  logic                            last_q;

  logic                            busy;
  logic                            adv;
  logic                            in_acc;
  logic                            cur_bit;
  logic                            cur_last;
  logic                            stuff_now;
  logic                            cfg_wr;
  hnabe_pkg::bit_req_t             req;
  logic                            coded_level;
  logic [hnabe_pkg::PHASE_W-1:0]   coded_phase;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrzi_q <= 1'b1;
    end else if (cfg_wr && (paddr[2] == hnabe_pkg::REG_NRZI_ENABLE)) begin
      nrzi_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hnabe_pkg::REG_NRZI_ENABLE) begin
      prdata[0] = nrzi_q;
    end
  end

  // handshake: a bit moves whenever the output register is free
  assign busy           = (rem_q != '0) || pend_q;
  assign adv            = busy && (!out_valid_q || out_chan.ready);
  assign in_chan.ready  = !busy || (adv && cur_last);
  assign in_acc         = in_chan.valid && in_chan.ready;

  // bit selection, ones run and last-bit detection
  assign cur_bit   = pend_q ? 1'b0 : data_q[0];
  assign ones_sum  = {1'b0, ones_q} + (hnabe_pkg::ONES_W + 1)'(1);
  assign stuff_now = stuff_q && data_q[0] &&
                     (ones_sum >= (hnabe_pkg::ONES_W + 1)'(hnabe_pkg::ONES_LIMIT));
  assign cur_last  = adv && (pend_q ? (rem_q == '0)
                                    : ((rem_q == hnabe_pkg::REM_W'(1)) && !stuff_now));

  always_comb begin
    data_d   = data_q;
    stuff_d  = stuff_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    ones_d   = ones_q;
    if (adv) begin
      if (pend_q) begin
        // inserted zero
        pend_d   = 1'b0;
        ones_d   = '0;
      end else begin
        data_d = data_q >> 1;
        rem_d  = rem_q - hnabe_pkg::REM_W'(1);
        if (stuff_q) begin
          if (stuff_now) begin
            pend_d = 1'b1;
            ones_d = '0;
          end else if (data_q[0]) begin
            ones_d = ones_sum[hnabe_pkg::ONES_W-1:0];
          end else begin
            ones_d = '0;
          end
        end
      end
    end
    // a new byte loads the shift register
    if (in_acc) begin
      data_d  = in_chan.data_byte;
      stuff_d = in_chan.stuff_enable;
      rem_d   = hnabe_pkg::REM_W'(hnabe_pkg::BYTE_BITS);
      pend_d  = 1'b0;
      if (in_chan.clear_ones) begin
        ones_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pend_q <= 1'b0;
      ones_q <= '0;
    end else begin
      rem_q  <= rem_d;
      pend_q <= pend_d;
      ones_q <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    stuff_q <= stuff_d;
  end

  // line coding and phase
  assign req.fire    = adv;
  assign req.bit_val = cur_bit;

  hnabe_line_coder u_coder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nrzi_en_i (nrzi_q),
    .req_i     (req),
    .level_o   (coded_level),
    .phase_o   (coded_phase)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_q   <= coded_level;
      phase_q   <= coded_phase;
      stuffed_q <= pend_q;
      last_q    <= cur_last;
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.line_level  = level_q;
  assign out_chan.phase_index = phase_q;
  assign out_chan.is_stuffed  = stuffed_q;
  assign out_chan.last_bit    = last_q;

endmodule

### hdl/hnabe_checker.sv
// ----------------------------------------------------------------------------
// hnabe_checker
// Port-level checks for the HDLC NRZI AFSK bit encoder.
// ----------------------------------------------------------------------------
module hnabe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          line_level_i,
  input logic [hnabe_pkg::PHASE_W-1:0] phase_index_i,
  input logic                          is_stuffed_i,
  input logic                          last_bit_i
);

  logic       in_acc;
  logic       out_acc;
  logic       prev_stuffed_q;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // bytes taken whose last bit has not yet been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q         <= '0;
      prev_stuffed_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc && last_bit_i);
      if (out_acc) begin
        prev_stuffed_q <= is_stuffed_i;
      end
    end
  end

  // phase stays within its cycle
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, phase_index_i} <
                     (hnabe_pkg::PHASE_W + 1)'(hnabe_pkg::PHASE_STEPS)))
    else $error("phase index out of range");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_level_i) &&
      $stable(phase_index_i) && $stable(is_stuffed_i) && $stable(last_bit_i))
    else $error("output item changed while stalled");

  // two inserted zeros never follow each other
  a_no_double_stuff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && is_stuffed_i |-> !prev_stuffed_q)
    else $error("inserted zero after inserted zero");

  // no output without a byte in flight, and at most two bytes in flight
  a_out_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("output item without a pending byte");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many bytes in flight");

endmodule

bind hdlc_nrzi_afsk_bit_encoder hnabe_checker u_hnabe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_chan.valid),
  .in_ready_i    (in_chan.ready),
  .out_valid_i   (out_chan.valid),
  .out_ready_i   (out_chan.ready),
  .line_level_i  (out_chan.line_level),
  .phase_index_i (out_chan.phase_index),
  .is_stuffed_i  (out_chan.is_stuffed),
  .last_bit_i    (out_chan.last_bit)
);

### tb/sv/tb_hdlc_nrzi_afsk_bit_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_nrzi_afsk_bit_encoder
// Self-checking bench for the HDLC stuffing / NRZI line bit encoder.
// ----------------------------------------------------------------------------
// Bytes go in on a valid/ready channel and the emitted line bits are taken
// on the other. A scoreboard class codes every accepted byte into the line
// bits it should produce (zero insertion, NRZI or plain level, phase step)
// and compares each emitted item field by field. The run walks through both
// coding modes, written over the APB-style port between phases, with random
// idling on both channels, one long output hold-off and one phase with no
// idling at all.
// ----------------------------------------------------------------------------
module tb_hdlc_nrzi_afsk_bit_encoder;

  localparam int REG_STRIDE = 4;
  localparam int SPARE_REG  = 1;
  localparam logic [hnabe_pkg::CFG_ADDR_W-1:0] NRZI_ADDR  =
    hnabe_pkg::CFG_ADDR_W'(hnabe_pkg::REG_NRZI_ENABLE * REG_STRIDE);
  localparam logic [hnabe_pkg::CFG_ADDR_W-1:0] SPARE_ADDR =
    hnabe_pkg::CFG_ADDR_W'(SPARE_REG * REG_STRIDE);

  localparam int IDLE_PCT     = 8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 3000;

  // one emitted line bit
  typedef struct packed {
    logic                          line_level;
    logic [hnabe_pkg::PHASE_W-1:0] phase_index;
    logic                          is_stuffed;
    logic                          last_bit;
  } line_bit_t;

  // codes accepted bytes into line bits and checks what comes out
  class nrzi_line_scoreboard;
    line_bit_t                   line_bits_due[$];
    bit                          nrzi_on;
    bit                          level;
    bit [hnabe_pkg::PHASE_W-1:0] phase;
    int unsigned                 ones_run;
    int unsigned                 errors;

    function new();
      nrzi_on  = 1'b1;
      level    = 1'b0;
      phase    = '0;
      ones_run = 0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return line_bits_due.size();
    endfunction

    // put one bit on the line, then step the phase after a space
    function void code_bit(bit b, bit stuffed);
      line_bit_t lb;
      if (nrzi_on) begin
        if (!b) level = ~level;
      end else begin
        level = b;
      end
      lb.line_level  = level;
      lb.phase_index = phase;
      lb.is_stuffed  = stuffed;
      lb.last_bit    = 1'b0;
      line_bits_due.push_back(lb);
      if (!level) begin
        if (phase == 0) phase = hnabe_pkg::PHASE_W'(hnabe_pkg::PHASE_STEPS - 1);
        else phase = phase - 1'b1;
      end
    endfunction

    // all line bits caused by one byte, lsb first
    function void encode_byte(logic [hnabe_pkg::BYTE_BITS-1:0] data, logic stuff, logic clr);
      bit b;
      if (clr) ones_run = 0;
      for (int i = 0; i < hnabe_pkg::BYTE_BITS; i++) begin
        b = data[i];
        code_bit(b, 1'b0);
        if (stuff) begin
          if (b) begin
            ones_run = (ones_run + 1) % 8;
            if (ones_run >= hnabe_pkg::ONES_LIMIT) begin
              code_bit(1'b0, 1'b1);
              ones_run = 0;
            end
          end else begin
            ones_run = 0;
          end
        end
      end
      line_bits_due[line_bits_due.size() - 1].last_bit = 1'b1;
    endfunction

    function void check_bit(logic lvl, logic [hnabe_pkg::PHASE_W-1:0] ph, logic stf,
                            logic lst);
      line_bit_t want;
      if (line_bits_due.size() == 0) begin
        $error("line bit with none due: level=%0b phase=%0d stuffed=%0b last=%0b",
               lvl, ph, stf, lst);
        errors++;
        return;
      end
      want = line_bits_due.pop_front();
      if (lvl !== want.line_level) begin
        $error("line_level: expected %0b, got %0b", want.line_level, lvl);
        errors++;
      end
      if (ph !== want.phase_index) begin
        $error("phase_index: expected %0d, got %0d", want.phase_index, ph);
        errors++;
      end
      if (stf !== want.is_stuffed) begin
        $error("is_stuffed: expected %0b, got %0b", want.is_stuffed, stf);
        errors++;
      end
      if (lst !== want.last_bit) begin
        $error("last_bit: expected %0b, got %0b", want.last_bit, lst);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [hnabe_pkg::CFG_ADDR_W-1:0] paddr;
  logic [hnabe_pkg::CFG_DATA_W-1:0] pwdata;
  logic [hnabe_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  logic hold_req;
  logic no_idle;
  int unsigned stall_cycles;

  nrzi_line_scoreboard line_sb = new();

  hnabe_byte_if byte_chan ();
  hnabe_bit_if  bit_chan ();

  hdlc_nrzi_afsk_bit_encoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (byte_chan),
    .out_chan (bit_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // line bit receiver: random idling, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    bit_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        bit_chan.ready <= 1'b0;
      end else if (no_idle) begin
        bit_chan.ready <= 1'b1;
      end else begin
        bit_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // monitor both channels and watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_chan.valid === 1'b1 && byte_chan.ready === 1'b1)
        line_sb.encode_byte(byte_chan.data_byte, byte_chan.stuff_enable, byte_chan.clear_ones);
      if (bit_chan.valid === 1'b1 && bit_chan.ready === 1'b1) begin
        line_sb.check_bit(bit_chan.line_level, bit_chan.phase_index, bit_chan.is_stuffed,
                          bit_chan.last_bit);
        stall_cycles = 0;
      end else if (byte_chan.valid === 1'b1 && byte_chan.ready === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // offer one byte and hold it until taken
  task automatic offer_byte(logic [hnabe_pkg::BYTE_BITS-1:0] data, logic stuff, logic clr);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      byte_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_chan.valid        <= 1'b1;
    byte_chan.data_byte    <= data;
    byte_chan.stuff_enable <= stuff;
    byte_chan.clear_ones   <= clr;
    do @(posedge clk_i); while (byte_chan.ready !== 1'b1);
  endtask

  // random bytes, biased toward runs of ones so that stuffing fires often
  task automatic send_random(int unsigned count);
    logic [hnabe_pkg::BYTE_BITS-1:0] d;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: d = hnabe_pkg::BYTE_BITS'($urandom_range(255));
        1: d = hnabe_pkg::BYTE_BITS'($urandom | $urandom);
        2: d = hnabe_pkg::BYTE_BITS'($urandom | $urandom | $urandom);
        default: d = hnabe_pkg::BYTE_BITS'($urandom & $urandom);
      endcase
      offer_byte(d, $urandom_range(99) < 80, $urandom_range(99) < 25);
    end
  endtask

  // stop offering and let every due line bit come out
  task automatic wait_drained();
    byte_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (line_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [hnabe_pkg::CFG_ADDR_W-1:0] addr,
                           logic [hnabe_pkg::CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == NRZI_ADDR) line_sb.nrzi_on = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NRZI_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== line_sb.nrzi_on) begin
      $error("nrzi_enable: expected %0b, got %0b", line_sb.nrzi_on, prdata[0]);
      line_sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    byte_chan.valid        <= 1'b0;
    byte_chan.data_byte    <= '0;
    byte_chan.stuff_enable <= 1'b0;
    byte_chan.clear_ones   <= 1'b0;
    hold_req               <= 1'b0;
    no_idle                <= 1'b0;
    stall_cycles           = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nrzi on from reset
    cfg_read_check();

    // directed: extremes, runs across bytes, clearing, stuffing off
    offer_byte(8'h00, 1'b1, 1'b1);
    offer_byte(8'hFF, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);  // run count held with stuffing off
    offer_byte(8'h03, 1'b1, 1'b0);  // run completes from the held count
    offer_byte(8'hF8, 1'b1, 1'b1);  // inserted zero is the last bit
    offer_byte(8'hC0, 1'b1, 1'b0);
    offer_byte(8'h07, 1'b1, 1'b0);  // run spans two bytes
    offer_byte(8'hC0, 1'b1, 1'b0);
    offer_byte(8'h07, 1'b1, 1'b1);  // same, but cleared first
    offer_byte(8'h1F, 1'b1, 1'b1);
    offer_byte(8'hAA, 1'b1, 1'b0);
    offer_byte(8'h55, 1'b1, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b0);  // many spaces, phase wraps
    offer_byte(8'h00, 1'b1, 1'b0);
    offer_byte(8'h7F, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b1, 1'b0);  // one inserted zero, nine bits
    offer_byte(8'hFF, 1'b0, 1'b1);
    offer_byte(8'h80, 1'b1, 1'b0);
    send_random(30);
    wait_drained();

    // level follows bit; spare address must be ignored
    cfg_write(NRZI_ADDR, 32'h0000_0000);
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    cfg_read_check();
    send_random(10);
    hold_req <= 1'b1;
    send_random(35);
    wait_drained();

    // nrzi back on through a full word, no idling on either side
    cfg_write(NRZI_ADDR, 32'hFFFF_FFFF);
    cfg_read_check();
    no_idle <= 1'b1;
    send_random(40);
    wait_drained();
    no_idle <= 1'b0;

    // only bit 0 counts
    cfg_write(NRZI_ADDR, 32'hFFFF_FFFE);
    cfg_read_check();
    send_random(40);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (line_sb.errors == 0 && line_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
